/* design/assert_macros.svh */
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the smoother checker. Expects clk_i and rst_ni in
// the scope where a macro is used.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SGFS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smoother checker: same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define SGFS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smoother checker: next-cycle implication failed");

`endif

/* design/sgfs_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sgfs_pkg
// Shared constants and types for the symmetric Gaussian FIR smoother.
// -----------------------------------------------------------------------------
package sgfs_pkg;

  // Default geometry
  localparam int HALF_TAPS_DEF        = 7;
  localparam int SAMPLE_BITS_DEF      = 24;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;

  // Config index width; covers up to 32 weights (HALF_TAPS up to 31)
  localparam int CFG_IDX_BITS = 5;

  // Tag that rides along each pipeline stage
  typedef struct packed {
    logic valid;
    logic last;
  } sgfs_tag_t;

endpackage

/* design/sgfs_ifs.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sgfs_ifs
// Valid/ready channel interfaces: sample input, smoothed output, weight writes.
// -----------------------------------------------------------------------------
interface sgfs_in_if #(
  parameter int SAMPLE_BITS = sgfs_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          trace_end;

  modport source (output valid, sample_in, trace_end, input ready);
  modport sink   (input valid, sample_in, trace_end, output ready);
endinterface

interface sgfs_out_if #(
  parameter int SAMPLE_BITS = sgfs_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] smoothed_out;
  logic                          last_out;

  modport source (output valid, smoothed_out, last_out, input ready);
  modport sink   (input valid, smoothed_out, last_out, output ready);
endinterface

interface sgfs_cfg_if #(
  parameter int WEIGHT_FRAC_BITS = sgfs_pkg::WEIGHT_FRAC_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [sgfs_pkg::CFG_IDX_BITS-1:0] index;
  logic [WEIGHT_FRAC_BITS:0]         wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

/* design/symmetric_gaussian_fir_smoother_core.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// symmetric_gaussian_fir_smoother_core
// Centered symmetric FIR smoother over a trace of signed samples, with
// software-loaded Q1.16 weights, rounding and saturation.
// -----------------------------------------------------------------------------
//
//   channel | dir | payload                    | accepted when
//   --------+-----+----------------------------+--------------------------
//   in_i    | in  | sample_in, trace_end       | in_i.valid & in_i.ready
//   out_o   | out | smoothed_out, last_out     | out_o.valid & out_o.ready
//   cfg_i   | in  | index, wdata (weight write)| cfg_i.valid & cfg_i.ready
//
// One sample per clock while stage 0 can advance and no flush is running. A request flagged trace_end is followed by
// HALF_TAPS flush shifts, one per cycle in which the window can advance,
// while zeros are shifted in and in_i.ready stays low.
// From the window shift, a result passes the registered pre-add,
// multiply, partial-sum, final-sum and round/saturate stages to out_o.
// Each stage carries its own valid bit and advances when the next one has
// room, so an output stall only backs up as far as the bubbles allow.
// Reset clears control and weights (center weight = 1.0); cfg_i.ready is
// always high.
// -----------------------------------------------------------------------------
module symmetric_gaussian_fir_smoother_core #(
  parameter int HALF_TAPS        = sgfs_pkg::HALF_TAPS_DEF,
  parameter int SAMPLE_BITS      = sgfs_pkg::SAMPLE_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = sgfs_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sgfs_cfg_if.sink   cfg_i,
  sgfs_in_if.sink    in_i,
  sgfs_out_if.source out_o
);
  import sgfs_pkg::*;

  // Geometry
  localparam int NW  = HALF_TAPS + 1;            // distinct weights
  localparam int WIN = 2 * HALF_TAPS + 1;        // window length
  localparam int WB  = WEIGHT_FRAC_BITS + 1;     // weight width
  localparam int PW  = SAMPLE_BITS + 1;          // symmetric pair sum
  localparam int MW  = PW + WB + 1;              // product
  localparam int AW  = MW + $clog2(NW + 1);      // accumulator (+ rounding)
  localparam int QW  = AW - WEIGHT_FRAC_BITS;    // after the fraction drops
  localparam int NG  = (NW + 3) / 4;             // partial-sum groups of four
  localparam int CW  = $clog2(HALF_TAPS + 1);    // seen / flush counters

  localparam logic [WB-1:0]        W_ONE = WB'(1) << WEIGHT_FRAC_BITS;
  localparam logic signed [AW-1:0] RND   = AW'(1) << (WEIGHT_FRAC_BITS - 1);
  localparam logic signed [QW-1:0] QMAX  =
    {{(QW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN  =
    {{(QW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Weight registers
  // ---------------------------------------------------------------------------
  logic [WB-1:0] weight_q [NW];
  logic          cfg_fire;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid & cfg_i.ready;

  // Writes to an index past the weight list fall through untouched.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NW; k++) begin
        weight_q[k] <= (k == 0) ? W_ONE : '0;
      end
    end else begin
      for (int k = 0; k < NW; k++) begin
        if (cfg_fire && (cfg_i.index == CFG_IDX_BITS'(k))) begin
          weight_q[k] <= cfg_i.wdata;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance chain (stage k moves when it is empty or stage k+1 moves)
  // ---------------------------------------------------------------------------
  sgfs_tag_t tag0_q, tag1_q, tag2_q, tag3_q, tag4_q, tag5_q;
  logic      adv0, adv1, adv2, adv3, adv4, adv5;

  assign adv5 = !tag5_q.valid || out_o.ready;
  assign adv4 = !tag4_q.valid || adv5;
  assign adv3 = !tag3_q.valid || adv4;
  assign adv2 = !tag2_q.valid || adv3;
  assign adv1 = !tag1_q.valid || adv2;
  assign adv0 = !tag0_q.valid || adv1;

  // ---------------------------------------------------------------------------
  // Stage 0: trace control and sample window
  // ---------------------------------------------------------------------------
  // seen_q counts samples of the trace (saturating at HALF_TAPS); once it
  // saturates, every shift produces a result centered HALF_TAPS back.
  // After trace_end, flush_q counts the zero shifts still to do; the last
  // one yields the final result. clr_q makes the next shift start from an
  // all-zero window, so the following trace sees zeros before its start.
  logic [CW-1:0]                 seen_q, seen_d;
  logic [CW-1:0]                 flush_q, flush_d;
  logic                          clr_q;
  logic                          flushing, in_fire, push, emit, last_push;
  logic signed [SAMPLE_BITS-1:0] push_sample;
  logic signed [SAMPLE_BITS-1:0] win_q [WIN];

  assign flushing    = (flush_q != '0);
  assign in_i.ready  = adv0 && !flushing;
  assign in_fire     = in_i.valid && in_i.ready;
  assign push        = in_fire || (flushing && adv0);
  assign push_sample = in_fire ? in_i.sample_in : '0;
  assign emit        = (seen_q == CW'(HALF_TAPS));
  assign last_push   = flushing && (flush_q == CW'(1));

  always_comb begin
    seen_d  = seen_q;
    flush_d = flush_q;
    if (push) begin
      if (last_push) begin
        seen_d = '0;
      end else if (!emit) begin
        seen_d = seen_q + CW'(1);
      end
    end
    if (in_fire && in_i.trace_end) begin
      flush_d = CW'(HALF_TAPS);
    end else if (flushing && adv0) begin
      flush_d = flush_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      flush_q <= '0;
      clr_q   <= 1'b1;
      tag0_q  <= '0;
    end else begin
      seen_q  <= seen_d;
      flush_q <= flush_d;
      if (push) begin
        clr_q        <= last_push;
        tag0_q.valid <= emit;
        tag0_q.last  <= last_push;
      end else if (adv1) begin
        tag0_q.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      win_q[0] <= push_sample;
      for (int i = 1; i < WIN; i++) begin
        win_q[i] <= clr_q ? '0 : win_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: fold symmetric taps
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] pair_d [NW];
  logic signed [PW-1:0] pair_q [NW];

  always_comb begin
    pair_d[0] = PW'(win_q[HALF_TAPS]);
    for (int d = 1; d < NW; d++) begin
      pair_d[d] = PW'(win_q[HALF_TAPS - d]) + PW'(win_q[HALF_TAPS + d]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: one multiplier per weight
  // ---------------------------------------------------------------------------
  logic signed [WB:0]   wsig [NW];
  logic signed [MW-1:0] prod_d [NW];
  logic signed [MW-1:0] prod_q [NW];

  always_comb begin
    for (int d = 0; d < NW; d++) begin
      wsig[d]   = $signed({1'b0, weight_q[d]});
      prod_d[d] = pair_q[d] * wsig[d];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: partial sums of four products
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0] grp_d [NG];
  logic signed [AW-1:0] grp_q [NG];

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < 4; j++) begin
        if (4 * g + j < NW) begin
          grp_d[g] = grp_d[g] + AW'(prod_q[4 * g + j]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: total plus half an LSB (round half up)
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0] acc_d, acc_q;

  always_comb begin
    acc_d = RND;
    for (int g = 0; g < NG; g++) begin
      acc_d = acc_d + grp_q[g];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: floor shift and saturate into the output register
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0]          shr;
  logic signed [QW-1:0]          quo;
  logic signed [SAMPLE_BITS-1:0] sat_d, sat_q;

  always_comb begin
    shr = acc_q >>> WEIGHT_FRAC_BITS;
    quo = shr[QW-1:0];
    if (quo > QMAX) begin
      sat_d = QMAX[SAMPLE_BITS-1:0];
    end else if (quo < QMIN) begin
      sat_d = QMIN[SAMPLE_BITS-1:0];
    end else begin
      sat_d = quo[SAMPLE_BITS-1:0];
    end
  end

  // Stage tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
      tag5_q <= '0;
    end else begin
      if (adv1) tag1_q <= tag0_q;
      if (adv2) tag2_q <= tag1_q;
      if (adv3) tag3_q <= tag2_q;
      if (adv4) tag4_q <= tag3_q;
      if (adv5) tag5_q <= tag4_q;
    end
  end

  // Stage data
  always_ff @(posedge clk_i) begin
    if (adv1 && tag0_q.valid) pair_q <= pair_d;
    if (adv2 && tag1_q.valid) prod_q <= prod_d;
    if (adv3 && tag2_q.valid) grp_q  <= grp_d;
    if (adv4 && tag3_q.valid) acc_q  <= acc_d;
    if (adv5 && tag4_q.valid) sat_q  <= sat_d;
  end

  assign out_o.valid        = tag5_q.valid;
  assign out_o.last_out     = tag5_q.last;
  assign out_o.smoothed_out = sat_q;

endmodule

/* design/sgfs_checker.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sgfs_checker
// Port-level checks on the smoother core, attached by bind.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module sgfs_checker #(
  parameter int SAMPLE_BITS = sgfs_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   in_trace_end_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] out_smoothed_i,
  input logic                   out_last_i
);

  // Result held until taken
  `SGFS_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)

  // Held result does not change
  `SGFS_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i,
                   $stable(out_smoothed_i) && $stable(out_last_i))

  // End of trace starts a flush: no request taken in the next cycle
  `SGFS_ASSERT_NXT(a_flush_blocks, in_valid_i && in_ready_i && in_trace_end_i,
                   !in_ready_i)

  // Pipeline comes out of reset empty
  `SGFS_ASSERT_IMP(a_reset_empty, $rose(rst_ni), !out_valid_i)

endmodule

bind symmetric_gaussian_fir_smoother_core sgfs_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_sgfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_trace_end_i (in_i.trace_end),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_smoothed_i (out_o.smoothed_out),
  .out_last_i     (out_o.last_out)
);
